@@ rtl/assert_macros.svh @@
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/prpf_pkg.sv @@
// Shared constants, types and field layout of the priority rule packet filter.
`timescale 1ns / 1ps

package prpf_pkg;

    // Table and log sizes.
    localparam int RULE_SLOTS = 64;
    localparam int LOG_LIMIT  = 256;

    localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(RULE_SLOTS + 1);
    localparam int LOG_W  = $clog2(LOG_LIMIT + 1);

    // Field widths of the beats.
    localparam int DIR_W    = 2;
    localparam int ACT_W    = 2;
    localparam int PORT_W   = 17;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int RSLOT_W  = 7;
    localparam int VERD_W   = 2;
    localparam int SEV_W    = 2;
    localparam int STAMP_W  = 8;
    localparam int HITS_W   = 16;
    localparam int TOTAL_W  = 24;
    localparam int FILL_W   = 9;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 120;

    // Opcodes carried in s_tuser.
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Status codes carried in m_tuser.
    localparam logic [STATUS_W-1:0] STATUS_ADDED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EVAL  = 2'd2;

    // Rule encodings.
    localparam logic [DIR_W-1:0]  DIR_BOTH     = 2'd2;
    localparam logic [PORT_W-1:0] PORT_ANY     = 17'h1FFFF;
    localparam logic [ACT_W-1:0]  ACT_ALLOW    = 2'b01;
    localparam logic [ACT_W-1:0]  ACT_INSPECT  = 2'b00;
    localparam logic [ACT_W-1:0]  ACT_RESERVED = 2'b10;
    localparam logic [ACT_W-1:0]  ACT_DENY     = 2'b11;

    // Start value, -1 as signed; only a rule of non-negative priority beats it.
    localparam logic [PRIO_W-1:0] PRIO_NONE = 8'hFF;

    // One stored rule.
    typedef struct packed {
        logic [DIR_W-1:0]  direction;
        logic [ACT_W-1:0]  action;
        logic [PORT_W-1:0] port;
        logic [PRIO_W-1:0] prio;
    } rule_t;

    // Best rule found so far by the scan.
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [ACT_W-1:0]  action;
        logic [PRIO_W-1:0] prio;
    } match_res_t;

    // Verdict totals and log fill.
    typedef struct packed {
        logic [TOTAL_W-1:0] allow;
        logic [TOTAL_W-1:0] deny;
        logic [TOTAL_W-1:0] inspect;
        logic [LOG_W-1:0]   fill;
    } stats_t;

endpackage

@@ rtl/priority_rule_packet_filter.sv @@
// Top level of the priority rule packet filter: sequencer, rule and hit memories.
`timescale 1ns / 1ps
//
// Usage: one request beat on the s_ channel gives exactly one result beat on
// the m_ channel. s_tuser selects the request: add a rule or evaluate a packet.
// An add beat writes the rule at the next free slot; once it is accepted the
// sequencer moves to its response state, which loads the output register and
// raises m_tvalid. An evaluate beat scans the held rules one per cycle
// through a single compare unit fed by the rule memory read port, then reads,
// bumps and writes back the hit counter of the winning rule and updates the
// verdict totals before the response state loads the result. Only one request
// is in flight: s_tready is high only while the sequencer is idle, so a new
// request is not taken before the last one has reached the output register.
// A finished result sits in the output register, so the next request is
// accepted while the receiver stalls; that request then holds in its last step
// until the output register frees. Reset empties the rule table and clears all
// totals and the log fill at once; no clearing pass is needed because a hit
// counter is zeroed when its rule is added.
//
module priority_rule_packet_filter
    import prpf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // direction[1:0], rule_action[3:2], port[20:4], priority_req[28:21]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // rule_slot[6:0], verdict[8:7], severity[10:9], logged[11],
    // timestamp[19:12], rule_hits[35:20], allowed_total[59:36],
    // denied_total[83:60], inspected_total[107:84], entries_logged[116:108]
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]  m_tuser
);

`include "assert_macros.svh"

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_HIT_RD = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Memories.
    rule_t             rule_mem [RULE_SLOTS];
    logic [HITS_W-1:0] hit_mem  [RULE_SLOTS];

    // Control registers.
    logic [CNT_W-1:0]  rules_used_reg;
    logic [CNT_W-1:0]  rules_used_next;
    logic [CNT_W-1:0]  issue_cnt_reg;
    logic [CNT_W-1:0]  issue_cnt_next;
    logic              rd_valid_reg;
    logic              rd_valid_next;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;

    // Payload registers.
    logic [SLOT_W-1:0]  rd_idx_reg;
    rule_t              rule_rd_reg;
    logic [HITS_W-1:0]  hit_rd_reg;
    logic [DIR_W-1:0]   pkt_dir_reg;
    logic [PORT_W-1:0]  pkt_port_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [RSLOT_W-1:0] res_slot_reg;
    logic [VERD_W-1:0]  res_verdict_reg;
    logic               res_logged_reg;
    logic [STAMP_W-1:0] res_stamp_reg;
    logic [HITS_W-1:0]  res_hits_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0]  m_tuser_reg;

    // Request fields.
    logic               req_accept;
    logic [DIR_W-1:0]   req_dir;
    logic [ACT_W-1:0]   req_act;
    logic [PORT_W-1:0]  req_port;
    logic [PRIO_W-1:0]  req_prio;
    logic               table_full;
    logic               add_go;
    rule_t              new_rule;

    // Datapath signals.
    logic               rd_en;
    logic               scan_clear;
    match_res_t         best;
    stats_t             stats;
    logic               tally;
    logic [VERD_W-1:0]  eval_verdict;
    logic [HITS_W-1:0]  hit_sat;
    logic               out_free;
    logic               out_load;

    // Request unpacking.
    assign req_accept = s_tvalid && s_tready;
    assign req_dir    = s_tdata[1:0];
    assign req_act    = s_tdata[3:2];
    assign req_port   = s_tdata[20:4];
    assign req_prio   = s_tdata[28:21];
    assign table_full = rules_used_reg >= CNT_W'(RULE_SLOTS);
    assign add_go     = req_accept && (s_tuser == OP_ADD) && !table_full;

    // The reserved action pattern is stored as inspect.
    always_comb begin
        new_rule.direction = req_dir;
        new_rule.action    = (req_act == ACT_RESERVED) ? ACT_INSPECT : req_act;
        new_rule.port      = req_port;
        new_rule.prio      = req_prio;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign rd_en    = (state_reg == ST_SCAN) && (issue_cnt_reg < rules_used_reg);
    assign scan_clear = req_accept && (s_tuser == OP_EVAL);
    assign tally    = (state_reg == ST_UPDATE);
    assign eval_verdict = best.found ? best.action : ACT_DENY;
    assign hit_sat  = (hit_rd_reg != '1) ? hit_rd_reg + 1'b1 : hit_rd_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_RESP) && out_free;

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        rules_used_next = rules_used_reg;
        issue_cnt_next  = issue_cnt_reg;
        rd_valid_next   = rd_en;
        m_tvalid_next   = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (req_accept) begin
                    if (s_tuser == OP_EVAL) begin
                        issue_cnt_next = '0;
                        state_next     = ST_SCAN;
                    end else begin
                        if (!table_full) begin
                            rules_used_next = rules_used_reg + 1'b1;
                        end
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end else if (!rd_valid_reg) begin
                    state_next = ST_HIT_RD;
                end
            end
            ST_HIT_RD: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rules_used_reg <= '0;
            issue_cnt_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rules_used_reg <= rules_used_next;
            issue_cnt_reg  <= issue_cnt_next;
            rd_valid_reg   <= rd_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Rule memory: written by an add, read once per scan step.
    always_ff @(posedge aclk) begin
        if (add_go) begin
            rule_mem[rules_used_reg[SLOT_W-1:0]] <= new_rule;
        end
        if (rd_en) begin
            rule_rd_reg <= rule_mem[issue_cnt_reg[SLOT_W-1:0]];
            rd_idx_reg  <= issue_cnt_reg[SLOT_W-1:0];
        end
    end

    // Hit counter memory: zeroed when a rule is added, bumped by a win.
    always_ff @(posedge aclk) begin
        if (add_go) begin
            hit_mem[rules_used_reg[SLOT_W-1:0]] <= '0;
        end else if (tally && best.found) begin
            hit_mem[best.slot] <= hit_sat;
        end
        if (state_reg == ST_HIT_RD) begin
            hit_rd_reg <= hit_mem[best.slot];
        end
    end

    prpf_match_unit u_match (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (scan_clear),
        .rule_valid (rd_valid_reg),
        .rule       (rule_rd_reg),
        .cand_slot  (rd_idx_reg),
        .pkt_dir    (pkt_dir_reg),
        .pkt_port   (pkt_port_reg),
        .best       (best)
    );

    prpf_stats u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tally   (tally),
        .verdict (eval_verdict),
        .stats   (stats)
    );

    // Result fields, set at request time for an add and after the scan
    // for an evaluate.
    always_ff @(posedge aclk) begin
        if (req_accept) begin
            pkt_dir_reg     <= req_dir;
            pkt_port_reg    <= req_port;
            res_verdict_reg <= ACT_INSPECT;
            res_logged_reg  <= 1'b0;
            res_stamp_reg   <= '0;
            res_hits_reg    <= '0;
            if (s_tuser == OP_EVAL) begin
                res_status_reg <= STATUS_EVAL;
                res_slot_reg   <= '1;
            end else if (table_full) begin
                res_status_reg <= STATUS_FULL;
                res_slot_reg   <= '1;
            end else begin
                res_status_reg <= STATUS_ADDED;
                res_slot_reg   <= RSLOT_W'(rules_used_reg[SLOT_W-1:0]);
            end
        end else if (tally) begin
            res_verdict_reg <= eval_verdict;
            res_slot_reg    <= best.found ? RSLOT_W'(best.slot) : '1;
            res_hits_reg    <= best.found ? hit_sat : '0;
            if (stats.fill < LOG_W'(LOG_LIMIT)) begin
                res_logged_reg <= 1'b1;
                res_stamp_reg  <= STAMP_W'(stats.fill);
            end
        end
    end

    // Output register; severity follows the verdict code.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tuser_reg <= res_status_reg;
            m_tdata_reg <= {3'b000,
                            FILL_W'(stats.fill),
                            stats.inspect,
                            stats.deny,
                            stats.allow,
                            res_hits_reg,
                            res_stamp_reg,
                            res_logged_reg,
                            res_verdict_reg,
                            res_verdict_reg,
                            res_slot_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks on table bookkeeping, scan bounds and counters.
    `ASSERT_ALWAYS(a_table_bound, aclk, aresetn, rules_used_reg <= CNT_W'(RULE_SLOTS), "rule count over table size")
    `ASSERT_IMPLY(a_scan_bound, aclk, aresetn, rd_en, issue_cnt_reg < rules_used_reg, "scan read past last rule")
    `ASSERT_IMPLY(a_best_prio, aclk, aresetn, best.found, !best.prio[PRIO_W-1], "negative priority rule won")
    `ASSERT_IMPLY(a_hit_nonzero, aclk, aresetn, tally && best.found, hit_sat != '0, "hit count of winner is zero")
    `ASSERT_NEXT(a_add_count, aclk, aresetn, add_go, rules_used_reg == $past(rules_used_reg) + 1'b1, "add did not take a slot")
    `ASSERT_ALWAYS(a_log_bound, aclk, aresetn, stats.fill <= LOG_W'(LOG_LIMIT), "log fill over limit")

endmodule

@@ rtl/prpf_match_unit.sv @@
// Shared rule compare unit: tests one rule a cycle and keeps the best match.
`timescale 1ns / 1ps

module prpf_match_unit
    import prpf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  logic              rule_valid,
    input  rule_t             rule,
    input  logic [SLOT_W-1:0] cand_slot,
    input  logic [DIR_W-1:0]  pkt_dir,
    input  logic [PORT_W-1:0] pkt_port,
    output match_res_t        best
);

    match_res_t best_reg;
    match_res_t best_next;
    logic       dir_hit;
    logic       port_hit;
    logic       prio_win;

    // Direction and port match, then a strict priority compare so the lower
    // index keeps a tie.
    always_comb begin
        dir_hit   = (rule.direction == DIR_BOTH) || (rule.direction == pkt_dir);
        port_hit  = (rule.port == PORT_ANY) || (rule.port == pkt_port);
        prio_win  = $signed(rule.prio) > $signed(best_reg.prio);
        best_next = best_reg;
        if (clear) begin
            best_next.found  = 1'b0;
            best_next.slot   = '0;
            best_next.action = ACT_DENY;
            best_next.prio   = PRIO_NONE;
        end else if (rule_valid && dir_hit && port_hit && prio_win) begin
            best_next.found  = 1'b1;
            best_next.slot   = cand_slot;
            best_next.action = rule.action;
            best_next.prio   = rule.prio;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg.found  <= 1'b0;
            best_reg.slot   <= '0;
            best_reg.action <= ACT_DENY;
            best_reg.prio   <= PRIO_NONE;
        end else begin
            best_reg <= best_next;
        end
    end

    assign best = best_reg;

endmodule

@@ rtl/prpf_stats.sv @@
// Saturating verdict totals and the event log fill counter.
`timescale 1ns / 1ps

module prpf_stats
    import prpf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             tally,
    input  logic [VERD_W-1:0] verdict,
    output stats_t           stats
);

    stats_t stats_reg;
    stats_t stats_next;

    // Bump the total that matches the verdict and take a log entry if room.
    always_comb begin
        stats_next = stats_reg;
        if (tally) begin
            if (verdict == ACT_ALLOW) begin
                if (stats_reg.allow != '1) begin
                    stats_next.allow = stats_reg.allow + 1'b1;
                end
            end else if (verdict == ACT_DENY) begin
                if (stats_reg.deny != '1) begin
                    stats_next.deny = stats_reg.deny + 1'b1;
                end
            end else begin
                if (stats_reg.inspect != '1) begin
                    stats_next.inspect = stats_reg.inspect + 1'b1;
                end
            end
            if (stats_reg.fill < LOG_W'(LOG_LIMIT)) begin
                stats_next.fill = stats_reg.fill + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stats_reg <= '0;
        end else begin
            stats_reg <= stats_next;
        end
    end

    assign stats = stats_reg;

endmodule
